@@ design/ibfp_pkg.sv @@
package ibfp_pkg;

	localparam int unsigned GYRO_SCALE_Q32  = 1199381;
	localparam int unsigned ACCEL_SCALE_Q32 = 8423848;
	localparam int unsigned WORD_FIRST_BYTE = 5;
	localparam int unsigned WORD_COUNT      = 6;

	typedef enum logic [2:0] {
		REG_CAL_MODE   = 3'd0,
		REG_CAL_TARGET = 3'd1,
		REG_YAW_BIAS   = 3'd2,
		REG_HEADER     = 3'd3,
		REG_TAIL       = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_end;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] gyro_x;
		logic signed [31:0] gyro_y;
		logic signed [31:0] gyro_z;
		logic signed [31:0] accel_x;
		logic signed [31:0] accel_y;
		logic signed [31:0] accel_z;
	} out_word_t;

	// one accepted frame: six raw big-endian words
	typedef struct packed {
		logic [5:0][15:0] raw;
	} frame_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCALE,
		BK_APPLY,
		BK_DIV,
		BK_OUT
	} bk_state_t;

endpackage

@@ design/ibfp_front.sv @@
module ibfp_front #(
	parameter int FRAME_BYTES = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ibfp_pkg::in_word_t   in_data,
	input  logic [7:0]           header_byte,
	input  logic [7:0]           tail_byte,
	output logic                 fr_valid,
	input  logic                 fr_ready,
	output ibfp_pkg::frame_t     fr_data
);
	import ibfp_pkg::*;

	localparam int PW = $clog2(FRAME_BYTES);

	logic [PW-1:0]   pos_q;
	logic            overrun_q;
	logic            hdr_ok_q;
	logic [5:0][15:0] raw_q;
	// two-entry queue toward the back end
	frame_t          qd_q [2];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;
	logic            push, pop, accept;
	logic [PW:0]     off;

	assign in_ready = (cnt_q != 2'd2);
	assign off      = {1'b0, pos_q} - (PW+1)'(WORD_FIRST_BYTE);
	assign accept   = in_valid && in_ready && in_data.frame_end && !overrun_q &&
		pos_q == PW'(FRAME_BYTES-1) && hdr_ok_q && in_data.rx_byte == tail_byte;
	assign push     = accept;
	assign pop      = fr_valid && fr_ready;
	assign fr_valid = (cnt_q != 2'd0);
	assign fr_data  = qd_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			overrun_q <= 1'b0;
			hdr_ok_q  <= 1'b0;
			wp_q      <= 1'b0;
			rp_q      <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (in_valid && in_ready) begin
				if (in_data.frame_end) begin
					pos_q     <= '0;
					overrun_q <= 1'b0;
					hdr_ok_q  <= 1'b0;
				end else begin
					if (!overrun_q && pos_q == '0)
						hdr_ok_q <= (in_data.rx_byte == header_byte);
					if (32'(pos_q) + 1 >= FRAME_BYTES)
						overrun_q <= 1'b1;
					else
						pos_q <= pos_q + 1'b1;
				end
			end
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready && !overrun_q &&
		    32'(pos_q) >= WORD_FIRST_BYTE && 32'(pos_q) < WORD_FIRST_BYTE + 2*WORD_COUNT) begin
			if (!off[0]) raw_q[off[3:1]][15:8] <= in_data.rx_byte;
			else         raw_q[off[3:1]][7:0]  <= in_data.rx_byte;
		end
		// the tail byte never lands in a word, so raw_q is complete here
		if (push) qd_q[wp_q].raw <= raw_q;
	end
endmodule

@@ design/ibfp_back.sv @@
module ibfp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fr_valid,
	output logic                  fr_ready,
	input  ibfp_pkg::frame_t      fr_data,
	input  logic                  cal_mode,
	input  logic [15:0]           cal_sample_target,
	input  logic signed [31:0]    fixed_yaw_bias,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ibfp_pkg::out_word_t   out_data
);
	import ibfp_pkg::*;

	bk_state_t          st_q, st_d;
	logic [2:0]         idx_q;                // scale/divide lane
	logic [5:0][15:0]   raw_q;
	logic signed [31:0] val_q [6];
	logic signed [47:0] sum_q [3];
	logic signed [31:0] bias_q [3];
	logic [15:0]        cnt_q;
	logic               rdy_q;
	logic               ov_q;
	out_word_t          res_q;
	// serial divider
	logic [47:0]        dq_q;
	logic [16:0]        drem_q;
	logic [5:0]         dbit_q;
	logic               dneg_q;

	logic signed [15:0] rw;
	logic signed [47:0] prod;
	logic signed [39:0] rnd;
	logic [16:0]        trial;
	logic [16:0]        cnt_next;
	logic signed [47:0] sv;
	logic [47:0]        mag;
	logic               half_up;

	assign rw   = raw_q[idx_q];
	assign prod = 48'(rw) * (idx_q < 3'd3 ? 48'(GYRO_SCALE_Q32) : 48'(ACCEL_SCALE_Q32));
	assign rnd  = 40'((prod + 48'sd128) >>> 8);
	assign trial = {drem_q[15:0], dq_q[47]};
	assign cnt_next = (cnt_q < cal_sample_target) ? {1'b0, cnt_q} + 17'd1 : {1'b0, cnt_q};
	assign sv   = sum_q[idx_q[1:0]];
	assign mag  = sv[47] ? 48'(-sv) : 48'(sv);
	// half away from zero: remainder*2 >= count
	assign half_up = ({drem_q, 1'b0} >= {2'b0, cnt_q});

	assign fr_ready  = (st_q == BK_IDLE);
	assign out_valid = ov_q;
	assign out_data  = res_q;

	function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] d;
		d = 33'(a) - 33'(b);
		if (d > 33'sh07FFFFFFF)       sat_sub = 32'sh7FFFFFFF;
		else if (d < -33'sh080000000) sat_sub = 32'sh80000000;
		else                          sat_sub = d[31:0];
	endfunction

	always_comb begin
		st_d = st_q;
		case (st_q)
			BK_IDLE:  if (fr_valid) st_d = BK_SCALE;
			BK_SCALE: if (idx_q == 3'd5) st_d = BK_APPLY;
			BK_APPLY: begin
				if (!cal_mode && cal_sample_target != '0 && !rdy_q)
					st_d = (cnt_next[15:0] < cal_sample_target) ? BK_IDLE : BK_DIV;
				else
					st_d = BK_OUT;
			end
			BK_DIV:  if (idx_q == 3'd2 && dbit_q == 6'd49) st_d = BK_IDLE;
			BK_OUT:  if (!ov_q) st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= BK_IDLE;
			idx_q <= '0;
			cnt_q <= '0;
			rdy_q <= 1'b0;
			ov_q  <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				sum_q[i]  <= '0;
				bias_q[i] <= '0;
			end
			dbit_q <= '0;
		end else begin
			st_q <= st_d;
			if (ov_q && out_ready) ov_q <= 1'b0;
			case (st_q)
				BK_IDLE: idx_q <= '0;
				BK_SCALE: idx_q <= (idx_q == 3'd5) ? 3'd0 : idx_q + 3'd1;
				BK_APPLY: begin
					if (!cal_mode && cal_sample_target != '0 && !rdy_q) begin
						for (int i = 0; i < 3; i++)
							sum_q[i] <= sum_q[i] + 48'(val_q[i]);
						cnt_q  <= cnt_next[15:0];
						dbit_q <= '0;
						idx_q  <= '0;
					end
				end
				BK_DIV: begin
					// restoring divide: one quotient bit a cycle, then round
					if (dbit_q == 6'd0) begin
						dq_q   <= mag;
						drem_q <= '0;
						dneg_q <= sv[47];
						dbit_q <= 6'd1;
					end else if (dbit_q <= 6'd48) begin
						if (trial >= {1'b0, cnt_q}) begin
							drem_q <= trial - {1'b0, cnt_q};
							dq_q   <= {dq_q[46:0], 1'b1};
						end else begin
							drem_q <= trial;
							dq_q   <= {dq_q[46:0], 1'b0};
						end
						dbit_q <= dbit_q + 6'd1;
					end else begin
						bias_q[idx_q[1:0]] <= dneg_q ?
							-(32'(dq_q) + 32'(half_up)) :
							32'(dq_q) + 32'(half_up);
						dbit_q <= '0;
						idx_q  <= idx_q + 3'd1;
						if (idx_q == 3'd2) rdy_q <= 1'b1;
					end
				end
				BK_OUT: if (!ov_q) ov_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == BK_IDLE && fr_valid) raw_q <= fr_data.raw;
		if (st_q == BK_SCALE) val_q[idx_q] <= rnd[31:0];
		// load only once the previous result has left
		if (st_q == BK_OUT && !ov_q) begin
			res_q.accel_x <= val_q[3];
			res_q.accel_y <= val_q[4];
			res_q.accel_z <= val_q[5];
			if (cal_mode) begin
				res_q.gyro_x <= val_q[0];
				res_q.gyro_y <= val_q[1];
				res_q.gyro_z <= sat_sub(val_q[2], fixed_yaw_bias);
			end else if (cal_sample_target != '0) begin
				res_q.gyro_x <= sat_sub(val_q[0], bias_q[0]);
				res_q.gyro_y <= sat_sub(val_q[1], bias_q[1]);
				res_q.gyro_z <= sat_sub(val_q[2], bias_q[2]);
			end else begin
				res_q.gyro_x <= val_q[0];
				res_q.gyro_y <= val_q[1];
				res_q.gyro_z <= val_q[2];
			end
		end
	end
endmodule

@@ design/imu_burst_frame_parser_bias_cal.sv @@
// IMU burst-frame parser with gyro bias calibration.
// in channel: one word per frame byte (rx_byte, frame_end marks the last byte).
// out channel: six signed Q7.24 values per accepted frame outside averaging.
// cfg port: cfg_we/cfg_idx/cfg_data, 0 cal_mode, 1 cal_sample_target,
//   2 fixed_yaw_bias, 3 header_byte, 4 tail_byte; other indexes ignored.
// The front end takes one byte per cycle while the queue has room, checks
// length, header and tail, assembles the six big-endian words and pushes a
// frame into a 2-deep queue. The back end scales the six words through one
// shared multiplier (one word a cycle), applies the bias and registers the
// result. The bias step at the end of averaging runs a serial divider for
// each axis in turn, once per calibration. Byte throughput is one per cycle
// while the queue has room; frames are bounded by the back end.
// Reset clears counters, queue, calibration state and registers to defaults.
// When the receiver stalls the result holds, the queue fills, and in_ready
// drops only when both queue entries are taken.
module imu_burst_frame_parser_bias_cal #(
	parameter int FRAME_BYTES = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ibfp_pkg::in_word_t    in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ibfp_pkg::out_word_t   out_data,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_idx,
	input  logic [31:0]           cfg_data
);
	import ibfp_pkg::*;

	logic               cal_mode_q;
	logic [15:0]        target_q;
	logic signed [31:0] yaw_q;
	logic [7:0]         header_q, tail_q;
	logic               fr_valid, fr_ready;
	frame_t             fr_data;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_mode_q <= 1'b0;
			target_q   <= '0;
			yaw_q      <= '0;
			header_q   <= 8'd128;
			tail_q     <= 8'd13;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_CAL_MODE:   cal_mode_q <= cfg_data[0];
				REG_CAL_TARGET: target_q   <= cfg_data[15:0];
				REG_YAW_BIAS:   yaw_q      <= cfg_data;
				REG_HEADER:     header_q   <= cfg_data[7:0];
				REG_TAIL:       tail_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	ibfp_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.header_byte(header_q), .tail_byte(tail_q),
		.fr_valid, .fr_ready, .fr_data
	);

	ibfp_back u_back (
		.clk, .arst_n, .fr_valid, .fr_ready, .fr_data,
		.cal_mode(cal_mode_q), .cal_sample_target(target_q), .fixed_yaw_bias(yaw_q),
		.out_valid, .out_ready, .out_data
	);
endmodule
